>>> src/tayexp_pkg.sv
// Package for the e^-x Taylor series block: field widths, register indexes,
// reset values and the command and status types shared by the controller and
// the datapath. No dependencies.
`default_nettype none

package tayexp_pkg;

   // Default number of fraction bits of the fixed-point format.
   localparam int FRAC_BITS_DEF = 30;

   // Fixed widths of the external fields.
   localparam int X_W     = 32;
   localparam int EXP_W   = 32;
   localparam int TOL_W   = 31;
   localparam int TERMS_W = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 31;

   // Width of one multiplier operand and of one division step.
   localparam int MUL_W       = 32;
   localparam int DIV_STEP_W  = 4;
   localparam int DIV_REM_W   = TERMS_W + 1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TERMS = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [TOL_W-1:0]   TOLERANCE_RST = 31'd1074;
   localparam logic [TERMS_W-1:0] MAX_TERMS_RST = 7'd100;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic mul_start;
      logic mul_issue;
      logic mul_acc;
      logic div_load;
      logic div_step;
      logic accum;
      logic finish;
   } tayexp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic range_err;
      logic go_on;
   } tayexp_stat_type;

endpackage

`default_nettype wire

>>> src/tayexp_dp.sv
// Datapath of the e^-x series: range check, term magnitude, running sum,
// a 32x32 chunked multiplier and a radix-16 restoring divider by the term index.
// Depends on tayexp_pkg.
`default_nettype none

module tayexp_dp
   import tayexp_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                clock,
   input  wire tayexp_cmd_type      cmd,
   output tayexp_stat_type          stat,
   input  wire logic [X_W-1:0]      x_value,
   input  wire logic [TOL_W-1:0]    tolerance,
   input  wire logic [TERMS_W-1:0]  max_terms,
   output logic [EXP_W-1:0]         exp_value,
   output logic                     range_err,
   output logic [TERMS_W-1:0]       terms_used
);

   localparam int MAG_W   = FRAC_BITS + 1;
   localparam int CH      = (MAG_W + MUL_W - 1) / MUL_W;
   localparam int MSH_W   = CH * MUL_W;
   localparam int ACC_W   = MSH_W + MUL_W;
   localparam int DIV_CYC = (MAG_W + DIV_STEP_W - 1) / DIV_STEP_W;
   localparam int DIV_W   = DIV_CYC * DIV_STEP_W;
   localparam int SUM_W   = MAG_W + 3;

   localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_BITS;

   // Operand registers.
   logic [X_W-1:0]           ax_ff, ax_in;
   logic                     xpos_ff, xpos_in;
   logic                     oor_ff, oor_in;
   logic [MAG_W-1:0]         tmag_ff, tmag_in;
   logic                     tneg_ff, tneg_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [TERMS_W-1:0]       n_ff, n_in;

   // Multiplier and divider registers.
   logic [MSH_W-1:0]         msh_ff, msh_in;
   logic [2*MUL_W-1:0]       pp_ff, pp_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [DIV_W-1:0]         dq_ff, dq_in;
   logic [DIV_REM_W-1:0]     rem_ff, rem_in;

   // Result registers.
   logic [EXP_W-1:0]         exp_ff, exp_in;
   logic                     oor_out_ff, oor_out_in;
   logic [TERMS_W-1:0]       terms_ff, terms_in;

   // Combinational helpers.
   logic signed [63:0]       x64;
   logic signed [63:0]       one64;
   logic                     oor_c;
   logic [X_W-1:0]           ax_c;
   logic [ACC_W-1:0]         acc_shift;
   logic [DIV_REM_W-1:0]     r_c;
   logic [DIV_W-1:0]         q_c;
   logic [DIV_REM_W-1:0]     div_c;
   logic [MAG_W-1:0]         tmag_new;
   logic                     tneg_new;
   logic signed [SUM_W-1:0]  term_s;
   logic signed [63:0]       sum64;

   always_comb begin
      x64   = 64'(signed'(x_value));
      one64 = 64'sd1 <<< FRAC_BITS;
      oor_c = (x64 <= -one64) || (x64 >= one64);
      ax_c  = x_value[X_W-1] ? (~x_value + X_W'(1)) : x_value;
   end

   // Four quotient bits per cycle; the remainder stays below the index.
   always_comb begin
      r_c   = rem_ff;
      q_c   = dq_ff;
      div_c = {1'b0, n_ff};
      for (int i = 0; i < DIV_STEP_W; i++) begin
         r_c = {r_c[DIV_REM_W-2:0], q_c[DIV_W-1]};
         q_c = q_c << 1;
         if (r_c >= div_c) begin
            r_c    = r_c - div_c;
            q_c[0] = 1'b1;
         end
      end
   end

   always_comb begin
      acc_shift = acc_ff >> FRAC_BITS;
      tmag_new  = MAG_W'(dq_ff);
      tneg_new  = tneg_ff ^ xpos_ff;
      term_s    = signed'({3'b000, tmag_new});
      sum64     = 64'(sum_ff);
   end

   always_comb begin
      ax_in      = ax_ff;
      xpos_in    = xpos_ff;
      oor_in     = oor_ff;
      tmag_in    = tmag_ff;
      tneg_in    = tneg_ff;
      sum_in     = sum_ff;
      n_in       = n_ff;
      msh_in     = msh_ff;
      pp_in      = pp_ff;
      acc_in     = acc_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      exp_in     = exp_ff;
      oor_out_in = oor_out_ff;
      terms_in   = terms_ff;

      if (cmd.load) begin
         ax_in   = ax_c;
         xpos_in = !x_value[X_W-1] && (x_value != '0);
         oor_in  = oor_c;
         tmag_in = ONE_MAG;
         tneg_in = 1'b0;
         sum_in  = signed'(SUM_W'(ONE_MAG));
         n_in    = TERMS_W'(1);
      end
      if (cmd.mul_start) begin
         msh_in = MSH_W'(tmag_ff);
         acc_in = '0;
      end
      if (cmd.mul_issue) begin
         pp_in  = (2*MUL_W)'(msh_ff[MSH_W-1 -: MUL_W]) * (2*MUL_W)'(ax_ff);
         msh_in = msh_ff << MUL_W;
      end
      if (cmd.mul_acc) begin
         acc_in = (acc_ff << MUL_W) + ACC_W'(pp_ff);
      end
      if (cmd.div_load) begin
         dq_in  = DIV_W'(MAG_W'(acc_shift));
         rem_in = '0;
      end
      if (cmd.div_step) begin
         dq_in  = q_c;
         rem_in = r_c;
      end
      if (cmd.accum) begin
         tmag_in = tmag_new;
         tneg_in = tneg_new;
         sum_in  = tneg_new ? (sum_ff - term_s) : (sum_ff + term_s);
         n_in    = n_ff + TERMS_W'(1);
      end
      if (cmd.finish) begin
         oor_out_in = oor_ff;
         terms_in   = n_ff;
         if (oor_ff || (sum64 < 64'sd0)) begin
            exp_in = '0;
         end else if (sum64 > 64'sh0_FFFF_FFFF) begin
            exp_in = '1;
         end else begin
            exp_in = sum64[EXP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      ax_ff      <= ax_in;
      xpos_ff    <= xpos_in;
      oor_ff     <= oor_in;
      tmag_ff    <= tmag_in;
      tneg_ff    <= tneg_in;
      sum_ff     <= sum_in;
      n_ff       <= n_in;
      msh_ff     <= msh_in;
      pp_ff      <= pp_in;
      acc_ff     <= acc_in;
      dq_ff      <= dq_in;
      rem_ff     <= rem_in;
      exp_ff     <= exp_in;
      oor_out_ff <= oor_out_in;
      terms_ff   <= terms_in;
   end

   always_comb begin
      stat.range_err = oor_ff;
      stat.go_on     = (64'(tmag_ff) > 64'(tolerance)) && (n_ff < max_terms);
   end

   assign exp_value  = exp_ff;
   assign range_err  = oor_out_ff;
   assign terms_used = terms_ff;

endmodule

`default_nettype wire

>>> src/tayexp_ctrl.sv
// Controller of the e^-x series: sequences range check, multiply, divide and
// accumulate for each term, and strobes the result.
// Depends on tayexp_pkg.
`default_nettype none

module tayexp_ctrl
   import tayexp_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output logic                  rsp_valid,
   output tayexp_cmd_type        cmd,
   input  wire tayexp_stat_type  stat
);

   localparam int MAG_W   = FRAC_BITS + 1;
   localparam int CH      = (MAG_W + MUL_W - 1) / MUL_W;
   localparam int DIV_CYC = (MAG_W + DIV_STEP_W - 1) / DIV_STEP_W;
   localparam int CNT_MAX = (CH > DIV_CYC - 1) ? CH : DIV_CYC - 1;
   localparam int CNT_W   = $clog2(CNT_MAX + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_MUL    = 3'd2;
   localparam logic [2:0] S_DIVL   = 3'd3;
   localparam logic [2:0] S_DIV    = 3'd4;
   localparam logic [2:0] S_ACCUM  = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.range_err || !stat.go_on) begin
               state_in = S_FINISH;
            end else begin
               cmd.mul_start = 1'b1;
               cnt_in        = '0;
               state_in      = S_MUL;
            end
         end
         S_MUL: begin
            // Chunks are issued high first; each partial product is registered and accumulated in the next cycle.
            cmd.mul_issue = (cnt_ff < CNT_W'(CH));
            cmd.mul_acc   = (cnt_ff != '0);
            if (cnt_ff == CNT_W'(CH)) begin
               cnt_in   = '0;
               state_in = S_DIVL;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_DIVL: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == CNT_W'(DIV_CYC - 1)) begin
               state_in = S_ACCUM;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = S_CHECK;
         end
         S_FINISH: begin
            cmd.finish   = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> src/taylor_exp_neg.sv
// e^-x by its Taylor series in fixed point. Each added term passes through the range
// check, the chunked multiplier, the divider load, the divider steps and the accumulate.
// A result is strobed after the check that ends the series; an out-of-range argument
// goes straight from its first check to the result.
// One transaction at a time: start is taken when busy is low, the next one in the
// cycle the result strobe shows. Synchronous reset idles the controller and
// restores the configuration registers.
`default_nettype none

module taylor_exp_neg
   import tayexp_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [X_W-1:0]         req_x_value,
   output logic                        rsp_valid,
   output logic [EXP_W-1:0]            rsp_exp_value,
   output logic                        rsp_range_err,
   output logic [TERMS_W-1:0]          rsp_terms_used,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [TOL_W-1:0]   tolerance_ff, tolerance_in;
   logic [TERMS_W-1:0] max_terms_ff, max_terms_in;
   tayexp_cmd_type     cmd;
   tayexp_stat_type    stat;

   always_comb begin
      tolerance_in = tolerance_ff;
      max_terms_in = max_terms_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TOLERANCE: tolerance_in = csr_wdata[TOL_W-1:0];
            CSR_MAX_TERMS: max_terms_in = csr_wdata[TERMS_W-1:0];
            default: begin
               tolerance_in = tolerance_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOLERANCE_RST;
         max_terms_ff <= MAX_TERMS_RST;
      end else begin
         tolerance_ff <= tolerance_in;
         max_terms_ff <= max_terms_in;
      end
   end

   tayexp_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   tayexp_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .stat       (stat),
      .x_value    (req_x_value),
      .tolerance  (tolerance_ff),
      .max_terms  (max_terms_ff),
      .exp_value  (rsp_exp_value),
      .range_err  (rsp_range_err),
      .terms_used (rsp_terms_used)
   );

endmodule

`default_nettype wire

>>> src/tayexp_chk.sv
// Port-level checker for taylor_exp_neg, attached by the bind at the end.
// Depends on tayexp_pkg.
`default_nettype none

module tayexp_chk
   import tayexp_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   start,
   input wire logic                   busy,
   input wire logic                   rsp_valid,
   input wire logic [EXP_W-1:0]       rsp_exp_value,
   input wire logic                   rsp_range_err,
   input wire logic [TERMS_W-1:0]     rsp_terms_used
);

   // An accepted transaction makes the block busy in the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted transaction");

   // The result strobe comes exactly when the block goes idle.
   a_fell_valid: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy fell without a result strobe");

   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_valid_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // An out-of-range argument gives zero after one term.
   a_range_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_err) |->
         (rsp_exp_value == '0) && (rsp_terms_used == TERMS_W'(1)))
      else $error("out-of-range result is not zero with one term");

endmodule

bind taylor_exp_neg tayexp_chk u_tayexp_chk (.*);

`default_nettype wire
